@@ rtl/cda_pkg.sv @@
// Shared constants, payload structs and inter-module types of the cepstral delta core.
package cda_pkg;

	// Geometry of the frame history
	localparam int MAX_COEFS  = 16;
	localparam int IDX_W      = (MAX_COEFS > 1) ? $clog2(MAX_COEFS) : 1;
	localparam int CNT_W      = IDX_W + 1;
	localparam int SLOT_W     = 2;
	localparam int ADDR_W     = SLOT_W + IDX_W;
	localparam int HIST_DEPTH = 1 << ADDR_W;

	// Datapath widths
	localparam int DATA_W      = 32;
	localparam int ACC_W       = 35;
	localparam int COEF_IDX_W  = 5;
	localparam int NUM_COEFS_W = 5;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 5;
	localparam int TAP_W       = 3;
	localparam int FS_W        = 3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_NUM_COEFS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INCL_DELTA = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INCL_ACCEL = 2'd2;

	localparam logic [NUM_COEFS_W-1:0] NUM_COEFS_RST = 5'd13;

	// Tap order within one result: prev2, prev1, current, next1, next2
	localparam logic [TAP_W-1:0] TAP_P2 = 3'd0;
	localparam logic [TAP_W-1:0] TAP_P1 = 3'd1;
	localparam logic [TAP_W-1:0] TAP_C  = 3'd2;
	localparam logic [TAP_W-1:0] TAP_N1 = 3'd3;
	localparam logic [TAP_W-1:0] TAP_N2 = 3'd4;

	typedef struct packed {
		logic signed [DATA_W-1:0] coef_value;
		logic                     end_of_sequence;
	} in_t;

	typedef struct packed {
		logic [COEF_IDX_W-1:0]    coef_index;
		logic signed [DATA_W-1:0] static_value;
		logic signed [DATA_W-1:0] delta_value;
		logic signed [DATA_W-1:0] accel_value;
		logic                     frame_done;
		logic                     sequence_done;
		logic                     run_last;
	} out_t;

	typedef struct packed {
		logic [NUM_COEFS_W-1:0] num_coefs;
		logic                   include_delta;
		logic                   include_accel;
	} cfg_t;

	typedef enum logic [1:0] {
		SRC_ZERO,
		SRC_MEM,
		SRC_X
	} tap_src_t;

	// Tap fetch request from the sequencer
	typedef struct packed {
		logic              vld;
		logic [TAP_W-1:0]  tap;
		tap_src_t          src;
		logic [ADDR_W-1:0] addr;
	} tap_req_t;

	// History write from the sequencer
	typedef struct packed {
		logic                     en;
		logic [ADDR_W-1:0]        addr;
		logic signed [DATA_W-1:0] data;
	} hist_wr_t;

	// Tap value arriving at the shared adder
	typedef struct packed {
		logic                     vld;
		logic [TAP_W-1:0]         tap;
		logic signed [DATA_W-1:0] value;
	} tap_arr_t;

	// Feature values of one finished result
	typedef struct packed {
		logic signed [DATA_W-1:0] static_value;
		logic signed [DATA_W-1:0] delta_value;
		logic signed [DATA_W-1:0] accel_value;
	} feat_t;

	// Result control from the sequencer to the output register
	typedef struct packed {
		logic                  go;
		logic [COEF_IDX_W-1:0] coef_index;
		logic                  frame_done;
		logic                  sequence_done;
		logic                  run_last;
	} emit_t;

endpackage

@@ rtl/cda_hist.sv @@
// Four-frame coefficient history memory with one registered read port and tap selection.
module cda_hist (
	input  logic                             clk,
	input  logic                             arst_n,
	input  cda_pkg::tap_req_t                req,
	input  cda_pkg::hist_wr_t                wr,
	input  logic signed [cda_pkg::DATA_W-1:0] x,
	output cda_pkg::tap_arr_t                arr
);

	logic [cda_pkg::DATA_W-1:0] mem [cda_pkg::HIST_DEPTH];
	logic [cda_pkg::DATA_W-1:0] rd_q;
	logic                       vld_s1;
	logic [cda_pkg::TAP_W-1:0]  tap_s1;
	cda_pkg::tap_src_t          src_s1;

	// Write the incoming coefficient, read one tap per cycle
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_q <= mem[req.addr];
	end

	// Track which tap the read data belongs to
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= req.vld;
		end
	end

	always_ff @(posedge clk) begin
		tap_s1 <= req.tap;
		src_s1 <= req.src;
	end

	// Substitute zero for absent frames and the live input for the newest tap
	always_comb begin
		arr.vld = vld_s1;
		arr.tap = tap_s1;
		case (src_s1)
			cda_pkg::SRC_MEM: arr.value = rd_q;
			cda_pkg::SRC_X:   arr.value = x;
			default:          arr.value = '0;
		endcase
	end

endmodule

@@ rtl/cda_alu.sv @@
// Shared add/subtract unit that folds the five taps into delta and acceleration.
module cda_alu (
	input  logic              clk,
	input  cda_pkg::tap_arr_t arr,
	input  logic              include_delta,
	input  logic              include_accel,
	output cda_pkg::feat_t    res
);

	logic signed [cda_pkg::ACC_W-1:0]  acc_q;
	logic signed [cda_pkg::ACC_W-1:0]  dlt_q;
	logic signed [cda_pkg::DATA_W-1:0] p1_q;
	logic signed [cda_pkg::DATA_W-1:0] c_q;
	logic signed [cda_pkg::ACC_W-1:0]  v_ext;
	logic signed [cda_pkg::ACC_W-1:0]  p1_ext;
	logic signed [cda_pkg::ACC_W-1:0]  opa;
	logic signed [cda_pkg::ACC_W-1:0]  opb;
	logic signed [cda_pkg::ACC_W-1:0]  sum;
	logic                              sub;

	assign v_ext  = {{(cda_pkg::ACC_W - cda_pkg::DATA_W){arr.value[cda_pkg::DATA_W-1]}},
		arr.value};
	assign p1_ext = {{(cda_pkg::ACC_W - cda_pkg::DATA_W){p1_q[cda_pkg::DATA_W-1]}}, p1_q};

	// Pick adder operands by tap: accel = p2 - 2c + n2, delta = n1 - p1
	always_comb begin
		opa = acc_q;
		opb = '0;
		sub = 1'b0;
		case (arr.tap)
			cda_pkg::TAP_P2: begin
				opa = '0;
				opb = v_ext;
			end
			cda_pkg::TAP_C: begin
				opb = v_ext <<< 1;
				sub = 1'b1;
			end
			cda_pkg::TAP_N1: begin
				opa = v_ext;
				opb = p1_ext;
				sub = 1'b1;
			end
			cda_pkg::TAP_N2: begin
				opb = v_ext;
			end
			default: begin
				opb = '0;
			end
		endcase
		sum = sub ? (opa - opb) : (opa + opb);
	end

	// Accumulate as taps arrive
	always_ff @(posedge clk) begin
		if (arr.vld) begin
			case (arr.tap)
				cda_pkg::TAP_P2: acc_q <= sum;
				cda_pkg::TAP_P1: p1_q <= arr.value;
				cda_pkg::TAP_C: begin
					acc_q <= sum;
					c_q   <= arr.value;
				end
				cda_pkg::TAP_N1: dlt_q <= sum;
				cda_pkg::TAP_N2: acc_q <= sum;
				default: acc_q <= acc_q;
			endcase
		end
	end

	// Arithmetic shifts are bit selects of the wide sums
	assign res.static_value = c_q;
	assign res.delta_value  = include_delta ? dlt_q[cda_pkg::DATA_W:1] : '0;
	assign res.accel_value  = include_accel ? acc_q[cda_pkg::DATA_W+1:2] : '0;

endmodule

@@ rtl/cda_seq.sv @@
// Sequencer: frame position tracking, tap fetch ordering, history write and flush.
module cda_seq (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  cda_pkg::in_t                      in_data,
	input  cda_pkg::cfg_t                     cfg,
	input  logic                              out_free,
	input  cda_pkg::tap_arr_t                 arr,
	output cda_pkg::tap_req_t                 req,
	output cda_pkg::hist_wr_t                 wr,
	output logic signed [cda_pkg::DATA_W-1:0] x,
	output cda_pkg::emit_t                    emit
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_EMIT,
		ST_WR
	} state_t;

	typedef enum logic [1:0] {
		MD_NORM,
		MD_F1,
		MD_F2
	} mode_t;

	state_t                            state_q;
	mode_t                             mode_q;
	logic [cda_pkg::IDX_W-1:0]         idx_q;
	logic [cda_pkg::IDX_W-1:0]         pos_q;
	logic [cda_pkg::SLOT_W-1:0]        head_q;
	logic [cda_pkg::FS_W-1:0]          fs_q;
	logic [cda_pkg::TAP_W-1:0]         iss_q;
	logic signed [cda_pkg::DATA_W-1:0] x_q;
	logic                              last_q;
	logic                              eos_q;

	logic [cda_pkg::CNT_W-1:0]  n_eff;
	logic                       pos_last;
	logic                       flush_last;
	logic [cda_pkg::TAP_W-1:0]  sh;
	logic [cda_pkg::TAP_W-1:0]  tap_sum;
	logic [cda_pkg::TAP_W-1:0]  bk;
	logic                       beyond;
	logic [cda_pkg::SLOT_W-1:0] slot;

	// Clamp the coefficient count to 1..MAX_COEFS
	always_comb begin
		if (cfg.num_coefs == '0) begin
			n_eff = cda_pkg::CNT_W'(1);
		end else if (cfg.num_coefs > cda_pkg::NUM_COEFS_W'(cda_pkg::MAX_COEFS)) begin
			n_eff = cda_pkg::CNT_W'(cda_pkg::MAX_COEFS);
		end else begin
			n_eff = cda_pkg::CNT_W'(cfg.num_coefs);
		end
	end

	assign pos_last   = (cda_pkg::CNT_W'(pos_q) + cda_pkg::CNT_W'(1)) >= n_eff;
	assign flush_last = (cda_pkg::CNT_W'(idx_q) + cda_pkg::CNT_W'(1)) == n_eff;

	// Frame distance of the tap being fetched; flush passes slide the window forward
	always_comb begin
		case (mode_q)
			MD_F1:   sh = 3'd1;
			MD_F2:   sh = 3'd2;
			default: sh = 3'd0;
		endcase
		tap_sum = iss_q + sh;
		beyond  = tap_sum > 3'd4;
		bk      = 3'd4 - tap_sum;
		slot    = head_q - bk[cda_pkg::SLOT_W-1:0];
	end

	// Tap fetch request
	always_comb begin
		req.vld  = (state_q == ST_RUN) && (iss_q <= cda_pkg::TAP_N2);
		req.tap  = iss_q;
		req.addr = {slot, idx_q};
		if (beyond || ((bk != '0) && (bk > fs_q))) begin
			req.src = cda_pkg::SRC_ZERO;
		end else if ((bk == '0) && (mode_q == MD_NORM)) begin
			req.src = cda_pkg::SRC_X;
		end else begin
			req.src = cda_pkg::SRC_MEM;
		end
	end

	// History write of the accepted coefficient
	assign wr.en   = (state_q == ST_WR);
	assign wr.addr = {head_q, idx_q};
	assign wr.data = x_q;
	assign x       = x_q;

	assign in_ready = (state_q == ST_IDLE);

	// Result tags
	always_comb begin
		emit.go         = (state_q == ST_EMIT) && out_free;
		emit.coef_index = cda_pkg::COEF_IDX_W'(idx_q);
		if (mode_q == MD_NORM) begin
			emit.frame_done    = last_q;
			emit.sequence_done = 1'b0;
			emit.run_last      = !eos_q;
		end else begin
			emit.frame_done    = flush_last;
			emit.sequence_done = (mode_q == MD_F2) && flush_last;
			emit.run_last      = (mode_q == MD_F2) && flush_last;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && in_valid) begin
			x_q <= in_data.coef_value;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q  <= MD_NORM;
			idx_q   <= '0;
			pos_q   <= '0;
			head_q  <= '0;
			fs_q    <= '0;
			iss_q   <= '0;
			last_q  <= 1'b0;
			eos_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						last_q <= pos_last;
						eos_q  <= in_data.end_of_sequence && pos_last;
						idx_q  <= pos_q;
						iss_q  <= '0;
						mode_q <= MD_NORM;
						state_q <= (fs_q >= 3'd2) ? ST_RUN : ST_WR;
					end
				end
				ST_RUN: begin
					if (req.vld) begin
						iss_q <= iss_q + 3'd1;
					end
					if (arr.vld && (arr.tap == cda_pkg::TAP_N2)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						iss_q <= '0;
						case (mode_q)
							MD_NORM: state_q <= ST_WR;
							MD_F1: begin
								state_q <= ST_RUN;
								if (flush_last) begin
									mode_q <= MD_F2;
									idx_q  <= '0;
								end else begin
									idx_q <= idx_q + cda_pkg::IDX_W'(1);
								end
							end
							default: begin
								if (flush_last) begin
									state_q <= ST_IDLE;
									mode_q  <= MD_NORM;
									head_q  <= '0;
									fs_q    <= '0;
									pos_q   <= '0;
								end else begin
									state_q <= ST_RUN;
									idx_q   <= idx_q + cda_pkg::IDX_W'(1);
								end
							end
						endcase
					end
				end
				ST_WR: begin
					if (!last_q) begin
						pos_q   <= idx_q + cda_pkg::IDX_W'(1);
						state_q <= ST_IDLE;
					end else if (!eos_q) begin
						pos_q   <= '0;
						head_q  <= head_q + cda_pkg::SLOT_W'(1);
						if (fs_q < 3'd4) begin
							fs_q <= fs_q + 3'd1;
						end
						state_q <= ST_IDLE;
					end else begin
						pos_q   <= '0;
						idx_q   <= '0;
						iss_q   <= '0;
						mode_q  <= (fs_q >= 3'd1) ? MD_F1 : MD_F2;
						state_q <= ST_RUN;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("sequencer ready right after taking a beat");

	a_no_emit_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		emit.go |-> !in_ready)
		else $error("result emitted while idle");

	a_fs_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fs_q <= 3'd4)
		else $error("frame count past four");

	a_rw_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.vld && wr.en))
		else $error("history read and write in the same cycle");

	a_seq_done_tags: assert property (@(posedge clk) disable iff (!arst_n)
		(emit.go && emit.sequence_done) |-> (emit.frame_done && emit.run_last))
		else $error("sequence end without frame end and run end");
`endif

endmodule

@@ rtl/cepstral_delta_accel_stream_core.sv @@
// Top level: configuration registers, output register and the delta/accel engine.
//
//  channel | signals                          | direction | beat
//  --------+----------------------------------+-----------+--------------------------
//  in      | in_valid, in_ready, in_data      | sink      | one static coefficient
//  out     | out_valid, out_ready, out_data   | source    | one static/delta/accel set
//  cfg     | cfg_valid, cfg_ready, cfg_index, | sink      | one register write
//          | cfg_data                         |           |
//
// A beat that gives no result only takes the history write step; one that gives a
// result first fetches taps and emits; each flushed result adds a fetch and emit run.
// Every result needs five taps through the single history read port feeding one
// shared 35-bit adder. Reset clears position, head, frame count and configuration;
// the history memory holds no reset state. A stalled output register holds the
// sequencer in its emit step; cfg writes are always taken.
module cepstral_delta_accel_stream_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  cda_pkg::in_t                       in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output cda_pkg::out_t                      out_data,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [cda_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cda_pkg::CFG_DATA_W-1:0]     cfg_data
);

	cda_pkg::cfg_t                     cfg_q;
	cda_pkg::tap_req_t                 req;
	cda_pkg::hist_wr_t                 wr;
	cda_pkg::tap_arr_t                 arr;
	cda_pkg::feat_t                    feat;
	cda_pkg::emit_t                    emit;
	logic signed [cda_pkg::DATA_W-1:0] x;
	cda_pkg::out_t                     out_q;
	logic                              out_vld_q;
	logic                              out_free;

	assign cfg_ready = 1'b1;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_coefs     <= cda_pkg::NUM_COEFS_RST;
			cfg_q.include_delta <= 1'b1;
			cfg_q.include_accel <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				cda_pkg::REG_NUM_COEFS:  cfg_q.num_coefs <= cfg_data;
				cda_pkg::REG_INCL_DELTA: cfg_q.include_delta <= cfg_data[0];
				cda_pkg::REG_INCL_ACCEL: cfg_q.include_accel <= cfg_data[0];
				default:                 cfg_q <= cfg_q;
			endcase
		end
	end

	cda_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.cfg      (cfg_q),
		.out_free (out_free),
		.arr      (arr),
		.req      (req),
		.wr       (wr),
		.x        (x),
		.emit     (emit)
	);

	cda_hist u_hist (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.wr     (wr),
		.x      (x),
		.arr    (arr)
	);

	cda_alu u_alu (
		.clk           (clk),
		.arr           (arr),
		.include_delta (cfg_q.include_delta),
		.include_accel (cfg_q.include_accel),
		.res           (feat)
	);

	// Output register: take a new result once the held beat leaves
	assign out_free = !out_vld_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (emit.go) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.go) begin
			out_q.coef_index    <= emit.coef_index;
			out_q.static_value  <= feat.static_value;
			out_q.delta_value   <= feat.delta_value;
			out_q.accel_value   <= feat.accel_value;
			out_q.frame_done    <= emit.frame_done;
			out_q.sequence_done <= emit.sequence_done;
			out_q.run_last      <= emit.run_last;
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

endmodule

@@ dv/cepstral_delta_accel_stream_core_test.sv @@
// Self-checking testbench of the cepstral delta/acceleration stream core.
`timescale 1ns / 100ps

module cepstral_delta_accel_stream_core_test;
	import cda_pkg::*;

	// Post-drain pause that lets the core go quiet before the next block
	localparam int SETTLE_CYCLES = 40;
	// Long receiver hold-off used to back the core up into its input
	localparam int HOLD_CYCLES   = 250;
	// Cycle count at which a hung run is aborted
	localparam int CYCLE_LIMIT   = 500000;
	localparam int RANDOM_ITEMS  = 340;

	localparam logic signed [DATA_W-1:0] COEF_MAX = 32'sh7fffffff;
	localparam logic signed [DATA_W-1:0] COEF_MIN = 32'sh80000000;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   in_valid  = 1'b0;
	logic                   in_ready;
	in_t                    in_data   = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	out_t                   out_data;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;

	// Expected result beats, oldest first
	out_t feature_q[$];
	int   mismatches  = 0;
	int   items_sent  = 0;
	int   cycle_count = 0;
	bit   no_idle     = 1'b0;
	bit   hold_req    = 1'b0;

	// Predictor state: frame history ring, position and shadow registers
	logic signed [DATA_W-1:0] coef_hist [4][MAX_COEFS];
	logic [1:0]               hist_head;
	int                       frames_held;
	int                       coef_pos;
	logic [NUM_COEFS_W-1:0]   shadow_num;
	logic                     shadow_delta;
	logic                     shadow_accel;

	cepstral_delta_accel_stream_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_count);
			$display("status: fail");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Feature predictor
	// ------------------------------------------------------------------

	function automatic int eff_count();
		if (shadow_num == 0)
			return 1;
		if (shadow_num > MAX_COEFS)
			return MAX_COEFS;
		return int'(shadow_num);
	endfunction

	// Coefficient j of the frame 'back' frames ago; absent frames read zero
	function automatic longint hist_tap(int back, int j);
		int slot;
		if (back > 0 && back > frames_held)
			return 0;
		slot = (int'(hist_head) + 8 - back) % 4;
		return longint'(coef_hist[slot][j]);
	endfunction

	function automatic out_t make_feature(int idx, longint p2, longint p1, longint c,
			longint n1, longint n2, bit fdone);
		out_t   r;
		longint d;
		longint a;
		d = shadow_delta ? ((n1 - p1) >>> 1) : 64'sd0;
		a = shadow_accel ? ((n2 - 2 * c + p2) >>> 2) : 64'sd0;
		r = '0;
		r.coef_index   = idx[COEF_IDX_W-1:0];
		r.static_value = c[DATA_W-1:0];
		r.delta_value  = d[DATA_W-1:0];
		r.accel_value  = a[DATA_W-1:0];
		r.frame_done   = fdone;
		return r;
	endfunction

	// Advance the predictor by one accepted coefficient and queue its results
	task automatic predict_features(logic signed [DATA_W-1:0] x, logic eos);
		int     n;
		int     j;
		int     i;
		bit     last;
		bit     ending;
		longint xv;
		out_t   batch[$];
		n      = eff_count();
		j      = coef_pos;
		last   = (j + 1 >= n);
		ending = eos && last;
		xv     = longint'(x);
		if (j >= MAX_COEFS)
			j = MAX_COEFS - 1;
		if (frames_held >= 2)
			batch.push_back(make_feature(j, hist_tap(4, j), hist_tap(3, j), hist_tap(2, j),
				hist_tap(1, j), xv, last));
		coef_hist[hist_head][j] = x;

		if (!last) begin
			coef_pos = j + 1;
		end else if (!ending) begin
			coef_pos = 0;
			hist_head++;
			if (frames_held < 4)
				frames_held++;
		end else begin
			// Flush the previous frame, then the one just completed
			if (frames_held >= 1)
				for (i = 0; i < n; i++)
					batch.push_back(make_feature(i, hist_tap(3, i), hist_tap(2, i),
						hist_tap(1, i), hist_tap(0, i), 0, i + 1 == n));
			for (i = 0; i < n; i++)
				batch.push_back(make_feature(i, hist_tap(2, i), hist_tap(1, i),
					hist_tap(0, i), 0, 0, i + 1 == n));
			batch[$].sequence_done = 1'b1;
			coef_pos    = 0;
			hist_head   = '0;
			frames_held = 0;
		end
		if (batch.size() > 0)
			batch[$].run_last = 1'b1;
		foreach (batch[k])
			feature_q.push_back(batch[k]);
	endtask

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------

	task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s expected 0x%08h actual 0x%08h", $time, name, want, got);
		end
	endtask

	// Compare each output beat with the oldest expectation
	always @(posedge clk) begin
		out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (feature_q.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result beat, expected none actual 0x%h",
					$time, out_data);
			end else begin
				want = feature_q.pop_front();
				check_field("coef_index", DATA_W'(want.coef_index),
					DATA_W'(out_data.coef_index));
				check_field("static_value", want.static_value, out_data.static_value);
				check_field("delta_value", want.delta_value, out_data.delta_value);
				check_field("accel_value", want.accel_value, out_data.accel_value);
				check_field("frame_done", DATA_W'(want.frame_done),
					DATA_W'(out_data.frame_done));
				check_field("sequence_done", DATA_W'(want.sequence_done),
					DATA_W'(out_data.sequence_done));
				check_field("run_last", DATA_W'(want.run_last), DATA_W'(out_data.run_last));
			end
		end
	end

	// Receiver: random stalls, bursts of full rate, and a long hold on request
	initial begin
		int r;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (no_idle) begin
				out_ready <= 1'b1;
				@(posedge clk);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 60) begin
					out_ready <= 1'b1;
					repeat ($urandom_range(1, 20)) @(posedge clk);
				end else if (r < 95) begin
					out_ready <= 1'b0;
					repeat ($urandom_range(1, 3)) @(posedge clk);
				end else begin
					out_ready <= 1'b0;
					repeat ($urandom_range(20, 60)) @(posedge clk);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic signed [DATA_W-1:0] rand_coef();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return $urandom;
		if (r < 75)
			return $urandom_range(0, 2000) - 1000;
		if (r < 88)
			return $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
		// within +/-8.0 in Q16.16
		return $urandom_range(0, 32'h100000) - 32'h80000;
	endfunction

	function automatic logic [NUM_COEFS_W-1:0] rand_num_coefs();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return NUM_COEFS_W'($urandom_range(1, 5));
		if (r < 80)
			return NUM_COEFS_W'($urandom_range(6, 15));
		if (r < 88)
			return NUM_COEFS_W'(MAX_COEFS);
		if (r < 94)
			return NUM_COEFS_W'($urandom_range(MAX_COEFS + 1, 31));
		return '0;
	endfunction

	// Send one coefficient beat after a random gap; valid stays up on return
	task automatic send_coef(logic signed [DATA_W-1:0] value, logic eos);
		int  gap;
		in_t beat;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		beat.coef_value      = value;
		beat.end_of_sequence = eos;
		in_data  <= beat;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		predict_features(value, eos);
		items_sent++;
	endtask

	// Drop input valid, drain expected results, then let the core go quiet
	task automatic settle_block();
		in_valid <= 1'b0;
		while (feature_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One config beat; valid is left high for a following beat
	task automatic cfg_beat(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_NUM_COEFS:  shadow_num   = data;
			REG_INCL_DELTA: shadow_delta = data[0];
			REG_INCL_ACCEL: shadow_accel = data[0];
			default: ;
		endcase
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		settle_block();
		cfg_beat(idx, data);
		cfg_valid <= 1'b0;
	endtask

	// Write all three registers back to back; upper bits of the flag words are junk
	task automatic configure(logic [NUM_COEFS_W-1:0] num, logic delta_on, logic accel_on);
		logic [CFG_DATA_W-1:0] word;
		settle_block();
		cfg_beat(REG_NUM_COEFS, num);
		word    = CFG_DATA_W'($urandom);
		word[0] = delta_on;
		cfg_beat(REG_INCL_DELTA, word);
		word    = CFG_DATA_W'($urandom);
		word[0] = accel_on;
		cfg_beat(REG_INCL_ACCEL, word);
		cfg_valid <= 1'b0;
	endtask

	// Frames of random coefficients, end mark on the last one; noise adds stray marks
	task automatic run_sequence(int frames, bit noise);
		int   n;
		int   f;
		int   j;
		logic eos;
		n = eff_count();
		for (f = 0; f < frames; f++)
			for (j = 0; j < n; j++) begin
				eos = (f == frames - 1) && (j == n - 1);
				if (noise && !eos && $urandom_range(0, 7) == 0)
					eos = 1'b1;
				send_coef(rand_coef(), eos);
			end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset configuration: one 13-coefficient frame, flushed alone
	task automatic test_reset_defaults();
		int j;
		for (j = 0; j < 13; j++)
			send_coef((j % 3 == 0) ? COEF_MAX : (j % 3 == 1) ? COEF_MIN : rand_coef(),
				j == 12);
	endtask

	// Zero count acts as one; full-scale swings drive the widest accel
	task automatic test_single_coef_frames();
		configure('0, 1'b1, 1'b1);
		send_coef(COEF_MAX, 1'b0);
		send_coef(COEF_MIN, 1'b0);
		send_coef(COEF_MAX, 1'b0);
		send_coef(COEF_MIN, 1'b0);
		send_coef(COEF_MAX, 1'b1);
	endtask

	// End marks off the frame boundary are ignored; delta disabled
	task automatic test_stray_end_mark();
		configure(5'd2, 1'b0, 1'b1);
		send_coef(rand_coef(), 1'b1);
		send_coef(rand_coef(), 1'b0);
		send_coef(COEF_MIN, 1'b1);
		send_coef(COEF_MAX, 1'b0);
		send_coef(rand_coef(), 1'b0);
		send_coef(rand_coef(), 1'b1);
	endtask

	// Shrink the count mid-frame so the current position closes the frame
	task automatic test_count_shrink();
		configure(5'd4, 1'b1, 1'b0);
		send_coef(rand_coef(), 1'b0);
		send_coef(rand_coef(), 1'b0);
		send_coef(rand_coef(), 1'b0);
		write_reg(REG_NUM_COEFS, 5'd2);
		send_coef(rand_coef(), 1'b0);
		send_coef(COEF_MIN, 1'b0);
		send_coef(COEF_MAX, 1'b0);
		send_coef(COEF_MAX, 1'b0);
		send_coef(COEF_MIN, 1'b1);
	endtask

	// Hold the output off long enough that the core backs up into its input
	task automatic test_output_backpressure();
		configure(5'd8, 1'b1, 1'b1);
		hold_req = 1'b1;
		run_sequence(4, 1'b0);
	endtask

	task automatic test_random_sequences();
		int stop_at;
		int frames;
		stop_at = items_sent + RANDOM_ITEMS;
		while (items_sent < stop_at) begin
			if ($urandom_range(0, 99) < 40)
				configure(rand_num_coefs(), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
			no_idle = ($urandom_range(0, 99) < 12);
			frames  = (eff_count() >= 12) ? $urandom_range(1, 3) : $urandom_range(1, 7);
			run_sequence(frames, $urandom_range(0, 99) < 20);
			no_idle = 1'b0;
		end
	endtask

	initial begin
		int s;
		int j;
		for (s = 0; s < 4; s++)
			for (j = 0; j < MAX_COEFS; j++)
				coef_hist[s][j] = '0;
		hist_head    = '0;
		frames_held  = 0;
		coef_pos     = 0;
		shadow_num   = NUM_COEFS_RST;
		shadow_delta = 1'b1;
		shadow_accel = 1'b1;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_single_coef_frames();
		test_stray_end_mark();
		test_count_shrink();
		test_output_backpressure();
		test_random_sequences();

		// Drain and watch for stray beats before the verdict
		settle_block();
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("%0t: %0d mismatches", $time, mismatches);
			$display("status: fail");
		end
		$finish;
	end

endmodule
